// File: hw/rtl/bsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsi_pkg
// Operation codes and the command/status bundles between the sequencer and
// the datapath of the bounded sorted-set intersection block.
// ----------------------------------------------------------------------------
package bsi_pkg;

    localparam logic [1:0] OP_PUSH_LEFT  = 2'd0;
    localparam logic [1:0] OP_PUSH_RIGHT = 2'd1;
    localparam logic [1:0] OP_RUN        = 2'd2;

    typedef struct packed {
        logic push_left;
        logic push_right;
        logic run_start;
        logic skip_adv;
        logic trim_dec;
        logic rd_trim;
        logic merge_i;
        logic merge_j;
        logic ld_elem;
        logic ld_sum;
    } t_cmd;

    typedef struct packed {
        logic j_lt_rend;
        logic i_lt_lcnt;
        logic r_lt_lo;
        logic r_gt_hi;
        logic a_lt_b;
        logic b_lt_a;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// File: hw/rtl/bsi_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsi_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: hw/rtl/bsi_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsi_datapath
// List stores, walk indices, bounds, match counter and result register.
// ----------------------------------------------------------------------------
module bsi_datapath #(
    parameter int LIST_DEPTH = 32,
    parameter int ID_WIDTH   = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bsi_pkg::t_cmd   i_cmd,
    output      bsi_pkg::t_status o_status,
    input  wire logic [31:0]     i_value,
    input  wire logic [31:0]     i_lower_bound,
    input  wire logic [31:0]     i_upper_bound,
    input  wire logic            i_ready,
    output      logic            o_valid,
    output      logic [31:0]     o_common_value,
    output      logic            o_is_element,
    output      logic [5:0]      o_match_count,
    output      logic            o_last
);
    import bsi_pkg::*;

    localparam int SW = (ID_WIDTH < 32) ? ID_WIDTH : 32;
    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

    logic [CW-1:0] r_i, n_i, r_j, n_j, r_rend, n_rend;
    logic [CW-1:0] r_lcnt, n_lcnt, r_rcnt, n_rcnt, r_n, n_n;
    logic [SW-1:0] r_lo, r_hi;
    logic          r_ovalid;
    logic [31:0]   r_ovalue;
    logic          r_oelem;
    logic [5:0]    r_ocnt;
    logic [SW-1:0] w_ldata, w_rdata;
    logic [AW-1:0] w_raddr_r;
    logic [CW-1:0] w_rend_m1;
    logic          w_lwe, w_rwe;

    assign w_lwe = i_cmd.push_left  && (r_lcnt != FULL);
    assign w_rwe = i_cmd.push_right && (r_rcnt != FULL);

    always_comb begin
        n_i    = r_i;
        n_j    = r_j;
        n_rend = r_rend;
        n_lcnt = r_lcnt;
        n_rcnt = r_rcnt;
        n_n    = r_n;
        if (i_cmd.run_start) begin
            n_i    = '0;
            n_j    = '0;
            n_rend = r_rcnt;
            n_n    = '0;
        end
        if (i_cmd.merge_i) begin
            n_i = r_i + 1'b1;
        end
        if (i_cmd.skip_adv || i_cmd.merge_j) begin
            n_j = r_j + 1'b1;
        end
        if (i_cmd.trim_dec) begin
            n_rend = r_rend - 1'b1;
        end
        if (i_cmd.ld_elem) begin
            n_n = r_n + 1'b1;
        end
        if (w_lwe) begin
            n_lcnt = r_lcnt + 1'b1;
        end
        if (w_rwe) begin
            n_rcnt = r_rcnt + 1'b1;
        end
        if (i_cmd.ld_sum) begin
            n_lcnt = '0;
            n_rcnt = '0;
        end
    end

    // read addresses follow the next index so data lines up with the index
    assign w_rend_m1 = n_rend - 1'b1;
    assign w_raddr_r = i_cmd.rd_trim ? w_rend_m1[AW-1:0] : n_j[AW-1:0];

    bsi_ram #(.WIDTH(SW), .DEPTH(LIST_DEPTH)) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (w_lwe),
        .i_waddr (r_lcnt[AW-1:0]),
        .i_wdata (i_value[SW-1:0]),
        .i_raddr (n_i[AW-1:0]),
        .o_rdata (w_ldata)
    );

    bsi_ram #(.WIDTH(SW), .DEPTH(LIST_DEPTH)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (w_rwe),
        .i_waddr (r_rcnt[AW-1:0]),
        .i_wdata (i_value[SW-1:0]),
        .i_raddr (w_raddr_r),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcnt   <= '0;
            r_rcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_lcnt <= n_lcnt;
            r_rcnt <= n_rcnt;
            if (i_cmd.ld_elem || i_cmd.ld_sum) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_rend <= n_rend;
        r_n    <= n_n;
        if (i_cmd.run_start) begin
            r_lo <= i_lower_bound[SW-1:0];
            r_hi <= i_upper_bound[SW-1:0];
        end
        if (i_cmd.ld_elem) begin
            r_ovalue <= 32'(w_rdata);
            r_oelem  <= 1'b1;
            r_ocnt   <= '0;
        end else if (i_cmd.ld_sum) begin
            r_ovalue <= '0;
            r_oelem  <= 1'b0;
            r_ocnt   <= 6'(r_n);
        end
    end

    always_comb begin
        o_status.j_lt_rend = r_j < r_rend;
        o_status.i_lt_lcnt = r_i < r_lcnt;
        o_status.r_lt_lo   = w_rdata < r_lo;
        o_status.r_gt_hi   = w_rdata > r_hi;
        o_status.a_lt_b    = w_ldata < w_rdata;
        o_status.b_lt_a    = w_rdata < w_ldata;
        o_status.out_free  = !r_ovalid || i_ready;
    end

    assign o_valid        = r_ovalid;
    assign o_common_value = r_ovalue;
    assign o_is_element   = r_oelem;
    assign o_match_count  = r_ocnt;
    assign o_last         = !r_oelem;

endmodule
`default_nettype wire

// File: hw/rtl/bsi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsi_ctrl
// Sequencer: loads, lower-bound skip, upper-bound trim, merge walk, summary.
// ----------------------------------------------------------------------------
module bsi_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output      logic             o_ready,
    input  wire logic [1:0]       i_operation,
    input  wire bsi_pkg::t_status i_status,
    output      bsi_pkg::t_cmd    o_cmd
);
    import bsi_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SKIP  = 3'd1;
    localparam logic [2:0] S_TRIM  = 3'd2;
    localparam logic [2:0] S_MERGE = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (i_operation)
                        OP_PUSH_LEFT:  o_cmd.push_left  = 1'b1;
                        OP_PUSH_RIGHT: o_cmd.push_right = 1'b1;
                        OP_RUN: begin
                            o_cmd.run_start = 1'b1;
                            n_state         = S_SKIP;
                        end
                        default: ;
                    endcase
                end
            end
            S_SKIP: begin
                if (i_status.j_lt_rend && i_status.r_lt_lo) begin
                    o_cmd.skip_adv = 1'b1;
                end else begin
                    o_cmd.rd_trim = 1'b1;
                    n_state       = S_TRIM;
                end
            end
            S_TRIM: begin
                if (i_status.j_lt_rend && i_status.r_gt_hi) begin
                    o_cmd.trim_dec = 1'b1;
                    o_cmd.rd_trim  = 1'b1;
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (!(i_status.i_lt_lcnt && i_status.j_lt_rend)) begin
                    n_state = S_SUM;
                end else if (i_status.a_lt_b) begin
                    o_cmd.merge_i = 1'b1;
                end else if (i_status.b_lt_a) begin
                    o_cmd.merge_j = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.ld_elem = 1'b1;
                    o_cmd.merge_i = 1'b1;
                    o_cmd.merge_j = 1'b1;
                end
            end
            S_SUM: begin
                if (i_status.out_free) begin
                    o_cmd.ld_sum = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/bounded_sorted_set_intersect.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_sorted_set_intersect
// Intersection of two ascending ID lists with bounds on the right list.
// ----------------------------------------------------------------------------
// Push transactions load one element into the left or right store; pushes to
// a full store are dropped. After a run transaction is accepted the input
// stays closed through the skip, trim, merge and summary phases: right
// elements below the lower bound are skipped, those above the upper bound
// are trimmed, then merge steps run, one per cycle unless the output stalls,
// each one read of each store's RAM port. Common elements stream out in
// order, then a summary transaction (last set) carries the match count and
// both stores are emptied. Output stalls hold the merge walk and the summary.
// ----------------------------------------------------------------------------
module bounded_sorted_set_intersect #(
    parameter int LIST_DEPTH = 32,
    parameter int ID_WIDTH   = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_value,
    input  wire logic [31:0] i_lower_bound,
    input  wire logic [31:0] i_upper_bound,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      logic [31:0] o_common_value,
    output      logic        o_is_element,
    output      logic [5:0]  o_match_count,
    output      logic        o_last
);
    import bsi_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    bsi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    bsi_datapath #(.LIST_DEPTH(LIST_DEPTH), .ID_WIDTH(ID_WIDTH)) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_value        (i_value),
        .i_lower_bound  (i_lower_bound),
        .i_upper_bound  (i_upper_bound),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_common_value (o_common_value),
        .o_is_element   (o_is_element),
        .o_match_count  (o_match_count),
        .o_last         (o_last)
    );

    a_elem_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ld_elem |-> w_status.out_free && !w_status.a_lt_b && !w_status.b_lt_a)
        else $error("element loaded without a match or a free slot");

    a_single_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.ld_elem && w_cmd.ld_sum))
        else $error("element and summary loaded together");

    a_no_accept_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !(w_cmd.skip_adv || w_cmd.trim_dec || w_cmd.merge_i
                      || w_cmd.merge_j || w_cmd.ld_sum))
        else $error("input ready while a run is in progress");

    a_elem_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ld_elem |=> o_valid && o_is_element && o_match_count == 6'd0)
        else $error("element transaction not presented correctly");

endmodule
`default_nettype wire

// File: bench/tb_bounded_sorted_set_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_sorted_set_intersect
// Self-checking bench for the bounded sorted-set intersection block. Loads
// pairs of ID lists, then issues bounded runs. Directed cases come first,
// then random list pairs. A local model predicts the common elements and
// summary of each run. Both handshakes idle at random outside a steady span.
// ----------------------------------------------------------------------------
module tb_bounded_sorted_set_intersect;
    import bsi_pkg::*;

    localparam int          LIST_DEPTH  = 32;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          RAND_ITEMS  = 150;
    localparam logic [1:0]  OP_IGNORED  = 2'd3;
    localparam logic [31:0] ID_MAX      = 32'hFFFF_FFFF;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] value;
        logic [31:0] lo;
        logic [31:0] hi;
        bit          steady;
    } t_req;

    typedef struct packed {
        logic [31:0] common_value;
        logic        is_element;
        logic [5:0]  match_count;
        logic        last;
    } t_isect_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_operation = '0;
    logic [31:0] i_value = '0;
    logic [31:0] i_lower_bound = '0;
    logic [31:0] i_upper_bound = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_common_value;
    logic        o_is_element;
    logic [5:0]  o_match_count;
    logic        o_last;

    t_req          req_queue[$];
    t_req          nxt;
    t_isect_result pending_results[$];
    t_isect_result want;
    logic [31:0]   left_ids[LIST_DEPTH];
    logic [31:0]   right_ids[LIST_DEPTH];
    int            left_fill = 0;
    int            right_fill = 0;
    bit            req_taken = 1'b0;
    bit            calm = 1'b0;
    int            stim_items = 0;
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            n_pushes = 0;
    int            n_runs = 0;
    int            n_ignored = 0;
    int            n_elements = 0;
    int            n_summaries = 0;

    bounded_sorted_set_intersect #(
        .LIST_DEPTH (LIST_DEPTH),
        .ID_WIDTH   (32)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .i_lower_bound  (i_lower_bound),
        .i_upper_bound  (i_upper_bound),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_common_value (o_common_value),
        .o_is_element   (o_is_element),
        .o_match_count  (o_match_count),
        .o_last         (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        $display("error @%0t: %s expected %0h got %0h", $realtime, what, exp_v, got_v);
        mismatch_count++;
    endtask

    task automatic queue_req(input logic [1:0] op, input logic [31:0] value,
                             input logic [31:0] lo, input logic [31:0] hi,
                             input bit steady);
        t_req r;
        r.op     = op;
        r.value  = value;
        r.lo     = lo;
        r.hi     = hi;
        r.steady = steady;
        req_queue.push_back(r);
        if (op != OP_IGNORED) stim_items++;
    endtask

    // Expected results of one accepted transaction
    task automatic intersect_predict(input logic [1:0] op, input logic [31:0] value,
                                     input logic [31:0] lo, input logic [31:0] hi);
        int            i;
        int            j;
        int            rend;
        int            n;
        t_isect_result res;
        case (op)
            OP_PUSH_LEFT: begin
                n_pushes++;
                if (left_fill < LIST_DEPTH) begin
                    left_ids[left_fill] = value;
                    left_fill++;
                end
            end
            OP_PUSH_RIGHT: begin
                n_pushes++;
                if (right_fill < LIST_DEPTH) begin
                    right_ids[right_fill] = value;
                    right_fill++;
                end
            end
            OP_RUN: begin
                n_runs++;
                i    = 0;
                j    = 0;
                n    = 0;
                rend = right_fill;
                while (j < rend && right_ids[j] < lo) j++;
                while (rend > j && right_ids[rend-1] > hi) rend--;
                while (i < left_fill && j < rend) begin
                    if (left_ids[i] < right_ids[j]) begin
                        i++;
                    end else if (right_ids[j] < left_ids[i]) begin
                        j++;
                    end else begin
                        res.common_value = right_ids[j];
                        res.is_element   = 1'b1;
                        res.match_count  = '0;
                        res.last         = 1'b0;
                        pending_results.push_back(res);
                        n++;
                        i++;
                        j++;
                    end
                end
                res.common_value = '0;
                res.is_element   = 1'b0;
                res.match_count  = n[5:0];
                res.last         = 1'b1;
                pending_results.push_back(res);
                left_fill  = 0;
                right_fill = 0;
            end
            default: begin
                n_ignored++;
            end
        endcase
    endtask

    // One list pair with bounds; mostly well-formed, some noise
    task automatic add_sequence();
        int          shape;
        int          nl;
        int          nr;
        logic [31:0] base;
        logic [31:0] v;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] lq[$];
        logic [31:0] rq[$];
        bit          steady;
        steady = (stim_items >= 90 && stim_items < 160);
        shape  = $urandom_range(0, 15);
        nl     = (shape == 0) ? $urandom_range(30, 34) : $urandom_range(0, 6);
        nr     = (shape <= 1) ? $urandom_range(30, 34) : $urandom_range(0, 6);
        base   = (shape < 6) ? $urandom : $urandom_range(0, 200);
        v = base;
        repeat (nl) begin
            lq.push_back((shape == 15) ? base + $urandom_range(0, 15) : v);
            v = v + $urandom_range(1, 3);
        end
        v = base + $urandom_range(0, 4);
        repeat (nr) begin
            rq.push_back((shape == 15) ? base + $urandom_range(0, 15) : v);
            v = v + $urandom_range(1, 3);
        end
        case ($urandom_range(0, 5))
            0: begin
                lo = '0;
                hi = ID_MAX;
            end
            1: begin
                lo = base + $urandom_range(0, 40);
                hi = lo;
            end
            2: begin
                hi = base + $urandom_range(0, 40);
                lo = hi + $urandom_range(1, 20);
            end
            3, 4: begin
                lo = base + $urandom_range(0, 20);
                hi = lo + $urandom_range(0, 60);
            end
            default: begin
                lo = $urandom;
                hi = $urandom;
            end
        endcase
        while (lq.size() > 0 || rq.size() > 0) begin
            if ($urandom_range(0, 19) == 0)
                queue_req(OP_IGNORED, $urandom, $urandom, $urandom, steady);
            if (rq.size() == 0 || (lq.size() > 0 && $urandom_range(0, 1) == 0))
                queue_req(OP_PUSH_LEFT, lq.pop_front(), $urandom, $urandom, steady);
            else
                queue_req(OP_PUSH_RIGHT, rq.pop_front(), $urandom, $urandom, steady);
        end
        if ($urandom_range(0, 9) != 0) queue_req(OP_RUN, $urandom, lo, hi, steady);
    endtask

    initial begin
        int rand_start;
        // empty stores, ignored opcode
        queue_req(OP_RUN, 32'h0, 32'h0, ID_MAX, 1'b0);
        queue_req(OP_IGNORED, ID_MAX, ID_MAX, ID_MAX, 1'b0);
        // extremes of the ID range
        queue_req(OP_PUSH_LEFT, 32'h0, ID_MAX, 32'h0, 1'b0);
        queue_req(OP_PUSH_LEFT, ID_MAX, 32'h0, ID_MAX, 1'b0);
        queue_req(OP_PUSH_RIGHT, 32'h0, 32'h0, 32'h0, 1'b0);
        queue_req(OP_PUSH_RIGHT, ID_MAX, ID_MAX, ID_MAX, 1'b0);
        queue_req(OP_RUN, ID_MAX, 32'h0, ID_MAX, 1'b0);
        // skip and trim on the right list
        queue_req(OP_PUSH_LEFT, 32'd5, 32'h0, 32'h0, 1'b0);
        queue_req(OP_PUSH_LEFT, 32'd7, 32'h0, 32'h0, 1'b0);
        queue_req(OP_PUSH_RIGHT, 32'd3, 32'h0, 32'h0, 1'b0);
        queue_req(OP_PUSH_RIGHT, 32'd5, 32'h0, 32'h0, 1'b0);
        queue_req(OP_PUSH_RIGHT, 32'd7, 32'h0, 32'h0, 1'b0);
        queue_req(OP_PUSH_RIGHT, 32'd9, 32'h0, 32'h0, 1'b0);
        queue_req(OP_RUN, 32'h0, 32'd4, 32'd8, 1'b0);
        // lower bound above upper bound
        queue_req(OP_PUSH_LEFT, 32'd4, 32'h0, 32'h0, 1'b0);
        queue_req(OP_PUSH_LEFT, 32'd6, 32'h0, 32'h0, 1'b0);
        queue_req(OP_PUSH_RIGHT, 32'd2, 32'h0, 32'h0, 1'b0);
        queue_req(OP_PUSH_RIGHT, 32'd4, 32'h0, 32'h0, 1'b0);
        queue_req(OP_PUSH_RIGHT, 32'd6, 32'h0, 32'h0, 1'b0);
        queue_req(OP_RUN, 32'h0, 32'd5, 32'd3, 1'b0);
        // unsorted lists
        queue_req(OP_PUSH_LEFT, 32'd9, 32'h0, 32'h0, 1'b0);
        queue_req(OP_PUSH_LEFT, 32'd1, 32'h0, 32'h0, 1'b0);
        queue_req(OP_PUSH_LEFT, 32'd5, 32'h0, 32'h0, 1'b0);
        queue_req(OP_PUSH_RIGHT, 32'd1, 32'h0, 32'h0, 1'b0);
        queue_req(OP_PUSH_RIGHT, 32'd9, 32'h0, 32'h0, 1'b0);
        queue_req(OP_PUSH_RIGHT, 32'd5, 32'h0, 32'h0, 1'b0);
        queue_req(OP_RUN, 32'h0, 32'h0, ID_MAX, 1'b0);

        rand_start = stim_items;
        while (stim_items < rand_start + RAND_ITEMS) add_sequence();
        queue_req(OP_RUN, $urandom, 32'h0, ID_MAX, 1'b0);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (req_queue.size() == 0 && !i_valid);
        wait (pending_results.size() == 0);
        repeat (200) @(posedge i_clk);

        $display("Ran %0d pushes, %0d runs and %0d ignored transactions", n_pushes, n_runs,
                 n_ignored);
        $display("Checked %0d common elements and %0d run summaries", n_elements,
                 n_summaries);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_ready <= 1'b0;
        end else begin
            if (!i_valid || req_taken) begin
                if (req_queue.size() > 0 &&
                    (req_queue[0].steady || $urandom_range(0, 99) >= 26)) begin
                    nxt = req_queue.pop_front();
                    i_valid       <= 1'b1;
                    i_operation   <= nxt.op;
                    i_value       <= nxt.value;
                    i_lower_bound <= nxt.lo;
                    i_upper_bound <= nxt.hi;
                    calm          <= nxt.steady;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= calm || ($urandom_range(0, 99) >= 26);
        end
    end

    // Input acceptance and prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_valid && o_ready;
            if (i_valid && o_ready)
                intersect_predict(i_operation, i_value, i_lower_bound, i_upper_bound);
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result, common_value", 32'h0, o_common_value);
            end else begin
                want = pending_results.pop_front();
                if (want.is_element) n_elements++;
                else n_summaries++;
                if (o_common_value !== want.common_value)
                    flag_mismatch("common_value", want.common_value, o_common_value);
                if (o_is_element !== want.is_element)
                    flag_mismatch("is_element", 32'(want.is_element), 32'(o_is_element));
                if (o_match_count !== want.match_count)
                    flag_mismatch("match_count", 32'(want.match_count), 32'(o_match_count));
                if (o_last !== want.last)
                    flag_mismatch("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
